>>> sv/u8x_pkg.sv
// shared types, codes and constants of the utf-8 xml character decoder
`default_nettype none

package u8x_pkg;

   // byte queue between the classifier and the sequence decoder
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   // field widths
   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned CodePointWidth = 21;
   localparam int unsigned StatusWidth    = 2;
   localparam int unsigned SeqLenWidth    = 3;

   // result status codes
   localparam logic [StatusWidth-1:0] STATUS_OK      = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_INVALID = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_EOF     = 2'd2;

   // range limits of the xml character rules
   localparam logic [CodePointWidth-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [CodePointWidth-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CodePointWidth-1:0] MAX_LOW_PLANE  = 21'h00D7FF;
   localparam logic [CodePointWidth-1:0] MIN_HIGH_PLANE = 21'h00E000;
   localparam logic [CodePointWidth-1:0] MAX_THREE_BYTE = 21'h00FFFD;
   localparam logic [CodePointWidth-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [CodePointWidth-1:0] MAX_CODE_POINT = 21'h10FFFF;

   // control character bound and the allowed control characters
   localparam logic [ByteWidth-1:0] CTRL_LIMIT = 8'h20;
   localparam logic [ByteWidth-1:0] CHAR_TAB   = 8'h09;
   localparam logic [ByteWidth-1:0] CHAR_LF    = 8'h0A;
   localparam logic [ByteWidth-1:0] CHAR_CR    = 8'h0D;

   // class of a raw byte, independent of decoder state
   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_ASCII_OK,
      CLS_ASCII_BAD,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD_LEAD
   } byte_class_type;

   // one queued byte with its class
   typedef struct packed {
      byte_class_type       cls;
      logic [ByteWidth-1:0] data;
   } entry_type;

endpackage

`default_nettype wire

>>> sv/u8x_front.sv
// front end: classifies each incoming byte before it is queued
`default_nettype none

module u8x_front (
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [u8x_pkg::ByteWidth-1:0] req_tdata,
   input  wire logic                         queue_full,
   output logic                              push,
   output u8x_pkg::entry_type                push_entry
);

   // the front takes an item whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // byte classification, in the priority order of the lead byte patterns
   always_comb begin
      push_entry.data = req_tdata;
      if (req_tdata == '0) begin
         push_entry.cls = u8x_pkg::CLS_NUL;
      end else if (req_tdata[7:3] == 5'b11110) begin
         push_entry.cls = u8x_pkg::CLS_LEAD4;
      end else if (req_tdata[7:4] == 4'b1110) begin
         push_entry.cls = u8x_pkg::CLS_LEAD3;
      end else if (req_tdata[7:5] == 3'b110) begin
         push_entry.cls = u8x_pkg::CLS_LEAD2;
      end else if (!req_tdata[7]) begin
         if (req_tdata < u8x_pkg::CTRL_LIMIT && req_tdata != u8x_pkg::CHAR_TAB &&
             req_tdata != u8x_pkg::CHAR_LF && req_tdata != u8x_pkg::CHAR_CR) begin
            push_entry.cls = u8x_pkg::CLS_ASCII_BAD;
         end else begin
            push_entry.cls = u8x_pkg::CLS_ASCII_OK;
         end
      end else if (req_tdata[7:6] == 2'b10) begin
         push_entry.cls = u8x_pkg::CLS_CONT;
      end else begin
         push_entry.cls = u8x_pkg::CLS_BAD_LEAD;
      end
   end

endmodule

`default_nettype wire

>>> sv/u8x_queue.sv
// short queue of classified bytes between front end and decoder
`default_nettype none

module u8x_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8x_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output u8x_pkg::entry_type      head_entry
);

   localparam int unsigned Depth = u8x_pkg::QueueDepth;
   localparam int unsigned PtrW  = u8x_pkg::QueuePtrWidth;
   localparam int unsigned CntW  = u8x_pkg::QueueCntWidth;
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   u8x_pkg::entry_type slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff,  count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/u8x_back.sv
// back end: gathers sequences, checks the xml rules and holds the result item
`default_nettype none

module u8x_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                head_valid,
   input  wire u8x_pkg::entry_type                  head_entry,
   output logic                                     pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [u8x_pkg::CodePointWidth-1:0]       code_point,
   output logic [u8x_pkg::StatusWidth-1:0]          status,
   output logic [u8x_pkg::SeqLenWidth-1:0]          seq_length
);

   localparam int unsigned CpW = u8x_pkg::CodePointWidth;

   logic [1:0]                        bytes_left_ff, bytes_left_in;
   logic [CpW-1:0]                    partial_ff,    partial_in;
   logic [u8x_pkg::SeqLenWidth-1:0]   lead_len_ff,   lead_len_in;
   logic                              valid_ff,      valid_in;
   logic [CpW-1:0]                    cp_ff,         cp_in;
   logic [u8x_pkg::StatusWidth-1:0]   status_ff,     status_in;
   logic [u8x_pkg::SeqLenWidth-1:0]   len_ff,        len_in;
   logic                              emit;
   logic [CpW-1:0]                    gathered;
   logic [1:0]                        left_dec;

   // range check of a completed multi-byte value
   function automatic logic value_ok(input logic [CpW-1:0] v,
                                     input logic [u8x_pkg::SeqLenWidth-1:0] len);
      logic ok;
      case (len)
         3'd2: ok = (v >= u8x_pkg::MIN_TWO_BYTE);
         3'd3: ok = !(v < u8x_pkg::MIN_THREE_BYTE ||
                      (v > u8x_pkg::MAX_LOW_PLANE && v < u8x_pkg::MIN_HIGH_PLANE) ||
                      v > u8x_pkg::MAX_THREE_BYTE);
         default: ok = !(v < u8x_pkg::MIN_FOUR_BYTE || v > u8x_pkg::MAX_CODE_POINT);
      endcase
      return ok;
   endfunction

   // take a queued item whenever the result register is free or drains
   assign pop = head_valid && (!valid_ff || rsp_tready);

   assign gathered = {partial_ff[CpW-7:0], head_entry.data[5:0]};
   assign left_dec = bytes_left_ff - 2'd1;

   // sequence decoding
   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      lead_len_in   = lead_len_ff;
      emit          = 1'b0;
      cp_in         = '0;
      status_in     = u8x_pkg::STATUS_INVALID;
      len_in        = 3'd1;
      if (pop) begin
         if (bytes_left_ff == 2'd0) begin
            case (head_entry.cls)
               u8x_pkg::CLS_NUL: begin
                  emit      = 1'b1;
                  status_in = u8x_pkg::STATUS_EOF;
                  len_in    = 3'd0;
               end
               u8x_pkg::CLS_LEAD4: begin
                  partial_in    = CpW'(head_entry.data[2:0]);
                  lead_len_in   = 3'd4;
                  bytes_left_in = 2'd3;
               end
               u8x_pkg::CLS_LEAD3: begin
                  partial_in    = CpW'(head_entry.data[3:0]);
                  lead_len_in   = 3'd3;
                  bytes_left_in = 2'd2;
               end
               u8x_pkg::CLS_LEAD2: begin
                  partial_in    = CpW'(head_entry.data[4:0]);
                  lead_len_in   = 3'd2;
                  bytes_left_in = 2'd1;
               end
               u8x_pkg::CLS_ASCII_OK: begin
                  emit      = 1'b1;
                  cp_in     = CpW'(head_entry.data);
                  status_in = u8x_pkg::STATUS_OK;
               end
               default: begin
                  // control character, stray continuation or bad lead
                  emit = 1'b1;
               end
            endcase
         end else if (head_entry.cls != u8x_pkg::CLS_CONT) begin
            // broken sequence: report and drop back to idle
            emit          = 1'b1;
            len_in        = lead_len_ff;
            bytes_left_in = 2'd0;
            partial_in    = '0;
            lead_len_in   = '0;
         end else begin
            partial_in    = gathered;
            bytes_left_in = left_dec;
            if (left_dec == 2'd0) begin
               emit        = 1'b1;
               len_in      = lead_len_ff;
               partial_in  = '0;
               lead_len_in = '0;
               if (value_ok(gathered, lead_len_ff)) begin
                  cp_in     = gathered;
                  status_in = u8x_pkg::STATUS_OK;
               end
            end
         end
      end
   end

   // result register valid
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = emit;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         partial_ff    <= '0;
         lead_len_ff   <= '0;
         valid_ff      <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         lead_len_ff   <= lead_len_in;
         valid_ff      <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         cp_ff     <= cp_in;
         status_ff <= status_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign code_point = cp_ff;
   assign status     = status_ff;
   assign seq_length = len_ff;

endmodule

`default_nettype wire

>>> sv/utf8_xml_char_decoder.sv
// top level of the utf-8 decoder with xml character checks
//
// Usage:
//   req_ channel carries one raw text byte per item. rsp_ channel carries one
//   result item per complete character, per error and per end-of-input mark;
//   lead bytes and middle continuation bytes give no result.
//   A result appears on rsp_ once the byte that ends it has been accepted
//   and has passed through the byte queue and then the result register.
//   Throughput: one byte per clock cycle sustained; the decoder takes one
//   queued byte a cycle, gated only by the result register draining.
//   A two-entry byte queue sits between the classifier and the decoder and a
//   registered result sits behind it, so req_tready can stay high while a
//   result waits; when rsp_tready is held low the queue fills and then
//   req_tready drops until results are taken.
//   Reset (synchronous, active high) empties the queue, drops any partial
//   sequence, clears rsp_tvalid and returns the decoder to waiting for a
//   lead byte.
`default_nettype none

module utf8_xml_char_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [20:0] code_point, [23:21] seq_length
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   logic                                  queue_full;
   logic                                  push;
   u8x_pkg::entry_type                    push_entry;
   logic                                  pop;
   logic                                  head_valid;
   u8x_pkg::entry_type                    head_entry;
   logic [u8x_pkg::CodePointWidth-1:0]    code_point;
   logic [u8x_pkg::StatusWidth-1:0]       status;
   logic [u8x_pkg::SeqLenWidth-1:0]       seq_length;

   // byte classification
   u8x_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // classified byte queue
   u8x_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // sequence decoder and result register
   u8x_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .code_point (code_point),
      .status     (status),
      .seq_length (seq_length)
   );

   assign rsp_tdata = {seq_length, code_point};
   assign rsp_tuser = status;

   // a rejected or end-of-input result never carries a code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != u8x_pkg::STATUS_OK |-> code_point == '0)
      else $error("non-ok result carries a code point");

   // end of input always reports a zero length, and only it does
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((status == u8x_pkg::STATUS_EOF) == (seq_length == 3'd0)))
      else $error("end-of-input status and length disagree");

   // an accepted character is a scalar value of legal length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == u8x_pkg::STATUS_OK |->
         code_point <= u8x_pkg::MAX_CODE_POINT && seq_length != 3'd0 &&
         seq_length <= 3'd4)
      else $error("accepted character out of range");

   // the queue only fills while results are being held back
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the utf-8 decoder with xml character checks
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomBytes = 1500;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned CpW         = u8x_pkg::CodePointWidth;

   // one expected result item
   typedef struct packed {
      logic [CpW-1:0]                  code_point;
      logic [u8x_pkg::StatusWidth-1:0] status;
      logic [u8x_pkg::SeqLenWidth-1:0] seq_length;
   } char_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [20:0] code_point, [23:21] seq_length
   logic [1:0]  rsp_tuser;            // [1:0] status

   logic [7:0]      text_bytes[$];
   char_result_type decoded_chars[$];

   // decoder state as seen by the predictor
   logic [1:0]                      cont_left = '0;
   logic [CpW-1:0]                  char_acc  = '0;
   logic [u8x_pkg::SeqLenWidth-1:0] lead_len  = '0;

   int   mismatch_cnt = 0;
   int   cycle_cnt    = 0;
   int   send_gap     = 0;
   int   rsp_stall    = 0;
   logic calm         = 1'b0;

   utf8_xml_char_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // wait drawn per item, none during calm stretches
   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 10);
   endfunction

   task automatic push_char(input logic [CpW-1:0] cp,
                            input logic [u8x_pkg::StatusWidth-1:0] st,
                            input logic [u8x_pkg::SeqLenWidth-1:0] len);
      char_result_type r;
      r.code_point = cp;
      r.status     = st;
      r.seq_length = len;
      decoded_chars.push_back(r);
   endtask

   // predict the result of one accepted byte
   task decode_byte(input logic [7:0] b);
      logic [u8x_pkg::SeqLenWidth-1:0] len;
      logic [CpW-1:0]                  v;
      logic                            ok;
      if (cont_left == 2'd0) begin
         if (b == 8'h00) begin
            push_char('0, u8x_pkg::STATUS_EOF, 3'd0);
         end else if (b[7:3] == 5'b11110) begin
            char_acc  = CpW'(b[2:0]);
            lead_len  = 3'd4;
            cont_left = 2'd3;
         end else if (b[7:4] == 4'b1110) begin
            char_acc  = CpW'(b[3:0]);
            lead_len  = 3'd3;
            cont_left = 2'd2;
         end else if (b[7:5] == 3'b110) begin
            char_acc  = CpW'(b[4:0]);
            lead_len  = 3'd2;
            cont_left = 2'd1;
         end else if (!b[7]) begin
            // control characters other than tab, lf and cr are rejected
            if (b < u8x_pkg::CTRL_LIMIT && b != u8x_pkg::CHAR_TAB &&
                b != u8x_pkg::CHAR_LF && b != u8x_pkg::CHAR_CR)
               push_char('0, u8x_pkg::STATUS_INVALID, 3'd1);
            else
               push_char(CpW'(b), u8x_pkg::STATUS_OK, 3'd1);
         end else begin
            push_char('0, u8x_pkg::STATUS_INVALID, 3'd1);
         end
      end else if (b[7:6] != 2'b10) begin
         // broken continuation, byte consumed and back to idle
         len       = lead_len;
         cont_left = '0;
         char_acc  = '0;
         lead_len  = '0;
         push_char('0, u8x_pkg::STATUS_INVALID, len);
      end else begin
         char_acc  = {char_acc[CpW-7:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            v        = char_acc;
            len      = lead_len;
            char_acc = '0;
            lead_len = '0;
            case (len)
               3'd2:    ok = (v >= u8x_pkg::MIN_TWO_BYTE);
               3'd3:    ok = !(v < u8x_pkg::MIN_THREE_BYTE ||
                               (v > u8x_pkg::MAX_LOW_PLANE && v < u8x_pkg::MIN_HIGH_PLANE)
                               || v > u8x_pkg::MAX_THREE_BYTE);
               default: ok = !(v < u8x_pkg::MIN_FOUR_BYTE || v > u8x_pkg::MAX_CODE_POINT);
            endcase
            if (ok) push_char(v, u8x_pkg::STATUS_OK, len);
            else    push_char('0, u8x_pkg::STATUS_INVALID, len);
         end
      end
   endtask

   // queue the first keep bytes of the len-byte form of cp
   task automatic put_char(input int unsigned cp, input int len, input int keep);
      logic [7:0] seq[4];
      case (len)
         2: begin
            seq[0] = 8'hC0 | 8'(cp[10:6]);
         end
         3: begin
            seq[0] = 8'hE0 | 8'(cp[15:12]);
            seq[1] = 8'h80 | 8'(cp[11:6]);
         end
         default: begin
            seq[0] = 8'hF0 | 8'(cp[20:18]);
            seq[1] = 8'h80 | 8'(cp[17:12]);
            seq[2] = 8'h80 | 8'(cp[11:6]);
         end
      endcase
      seq[len-1] = 8'h80 | 8'(cp[5:0]);
      for (int i = 0; i < keep; i++) text_bytes.push_back(seq[i]);
   endtask

   // stimulus, end of run and verdict
   initial begin
      int unsigned edges[$];
      int unsigned cp;
      int          kind;
      int          len;
      logic [7:0]  b;
      edges = '{'h7f, 'h80, 'h9f, 'h7ff, 'h800, 'hd7ff, 'hd800, 'hdfff, 'he000, 'hfffd,
                'hfffe, 'hffff, 'h10000, 'h10ffff, 'h110000, 'h1fffff};

      // single bytes: plain, end of input, allowed and rejected controls, stray continuations, bad leads
      text_bytes = '{8'h41, 8'h00, 8'h09, 8'h0A, 8'h0D, 8'h01, 8'h1F, 8'h20, 8'h7F,
                     8'h80, 8'hBF, 8'hF8, 8'hFF};
      // range limits of each length
      put_char('h80, 2, 2);
      put_char('h7f, 2, 2);
      put_char('h7ff, 2, 2);
      put_char('h800, 3, 3);
      put_char('h7ff, 3, 3);
      put_char('hd800, 3, 3);
      put_char('he000, 3, 3);
      put_char('hfffe, 3, 3);
      put_char('hffff, 4, 4);
      put_char('h10ffff, 4, 4);
      put_char('h110000, 4, 4);
      // broken continuation, also by a nul byte
      put_char('h2022, 3, 1);
      text_bytes.push_back(8'h41);
      put_char('he9, 2, 1);
      text_bytes.push_back(8'h00);

      // random part: mostly well-formed characters, some broken and some noise
      while (text_bytes.size() < RandomBytes + 40) begin
         kind = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (kind < 15) begin
            text_bytes.push_back(8'($urandom_range(0, 127)));
         end else if (kind < 68) begin
            put_char($urandom_range(0, (1 << (5 * len + 1)) - 1), len, len);
         end else if (kind < 82) begin
            cp = edges[$urandom_range(0, edges.size() - 1)] + $urandom_range(0, 4) - 2;
            put_char(cp & ((1 << (5 * len + 1)) - 1), len, len);
         end else if (kind < 92) begin
            put_char($urandom_range(0, (1 << (5 * len + 1)) - 1), len,
                     $urandom_range(1, len - 1));
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            text_bytes.push_back(b);
         end else begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (text_bytes.size() != 0 || req_tvalid);
      do @(posedge clock); while (decoded_chars.size() != 0);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_cnt == 0 && decoded_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // calm stretches with no idling on either side
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) calm <= ~calm;
   end

   // byte driver, predicts each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (text_bytes.size() > 0) begin
               req_tdata  <= text_bytes.pop_front();
               req_tvalid <= 1'b1;
               send_gap = draw_wait();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : result_monitor
      char_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_chars.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected result item: code_point %h status %0d seq_length %0d",
                           rsp_tdata[20:0], rsp_tuser, rsp_tdata[23:21]);
            end else begin
               want = decoded_chars.pop_front();
               if (rsp_tdata[20:0] !== want.code_point || rsp_tuser !== want.status
                   || rsp_tdata[23:21] !== want.seq_length) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                              want.code_point, want.status, want.seq_length,
                              rsp_tdata[20:0], rsp_tuser, rsp_tdata[23:21]);
               end
            end
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

`default_nettype wire
